/* rtl/core/qalu_pkg.sv */
// Shared types, opcodes and saturation helper for the quaternion arithmetic unit.
package qalu_pkg;

	localparam int QALU_FRAC_BITS = 16;
	localparam int WORD_W = 32;
	localparam int N_MUL = 16;
	localparam int N_MAT = 9;

	localparam logic [3:0] OP_ADD   = 4'd0;
	localparam logic [3:0] OP_SUB   = 4'd1;
	localparam logic [3:0] OP_NEG   = 4'd2;
	localparam logic [3:0] OP_SCALE = 4'd3;
	localparam logic [3:0] OP_MUL   = 4'd4;
	localparam logic [3:0] OP_CONJ  = 4'd5;
	localparam logic [3:0] OP_MAT   = 4'd6;
	localparam logic [3:0] OP_MAG   = 4'd7;
	localparam logic [3:0] OP_NORM  = 4'd8;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic [3:0]          opcode;
		logic signed [31:0]  a_w;
		logic signed [31:0]  a_x;
		logic signed [31:0]  a_y;
		logic signed [31:0]  a_z;
		logic signed [31:0]  b_w;
		logic signed [31:0]  b_x;
		logic signed [31:0]  b_y;
		logic signed [31:0]  b_z;
	} qalu_in_t;

	typedef struct packed {
		logic signed [31:0] c0;
		logic signed [31:0] c1;
		logic signed [31:0] c2;
		logic signed [31:0] c3;
		logic [1:0]         row;
		logic               last;
		logic               saturated;
	} qalu_out_t;

	// Everything an item carries alongside the root and divide pipelines.
	typedef struct packed {
		logic [3:0]              op;
		word_t [3:0]             res;
		logic                    res_sat;
		word_t [N_MAT-1:0]       mat;
		logic [2:0]              row_sat;
		word_t [3:0]             a;
	} qalu_side_t;

	// Returns {flag, word}: the value clamped to the signed 32-bit range.
	function automatic logic [32:0] sat_word(input logic signed [67:0] v);
		logic [32:0] r;
		if (v > 68'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -68'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

/* rtl/core/qalu_stream_if.sv */
// Valid/ready stream channel carrying one payload of a given type.
interface qalu_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/qalu_front.sv */
// Front pipeline: operand selection, sixteen multipliers, sums, rounding and saturation.
module qalu_front #(
	parameter int FRAC_BITS = qalu_pkg::QALU_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  qalu_pkg::qalu_in_t    in_data,
	output logic                  out_valid,
	output logic [64:0]           sq_sum,
	output qalu_pkg::qalu_side_t  out_side
);
	import qalu_pkg::*;

	localparam logic signed [67:0] HALF = 68'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [67:0] ONE  = 68'sd1 <<< FRAC_BITS;
	// Product slots whose term is subtracted in the Hamilton product.
	localparam logic [N_MUL-1:0] MUL_NEG = 16'h222E;
	// Operand codes: 0..3 are a_w..a_z, 4..7 are b_w..b_z.
	localparam logic [2:0] MUL_X_SEL [N_MUL] =
		'{3'd0, 3'd1, 3'd2, 3'd3, 3'd2, 3'd3, 3'd0, 3'd4,
		  3'd3, 3'd1, 3'd0, 3'd4, 3'd1, 3'd2, 3'd0, 3'd4};
	localparam logic [2:0] MUL_Y_SEL [N_MUL] =
		'{3'd4, 3'd5, 3'd6, 3'd7, 3'd7, 3'd6, 3'd5, 3'd1,
		  3'd5, 3'd7, 3'd6, 3'd2, 3'd6, 3'd5, 3'd7, 3'd3};
	// Matrix products: xx, yy, zz, xy, xz, yz, wx, wy, wz.
	localparam logic [1:0] MAT_X_SEL [N_MAT] =
		'{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0};
	localparam logic [1:0] MAT_Y_SEL [N_MAT] =
		'{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3};
	// Each matrix element is 2*(+-pa +-pb), plus one on the diagonal.
	localparam logic [3:0] MAT_PA [N_MAT] =
		'{4'd1, 4'd3, 4'd4, 4'd3, 4'd0, 4'd5, 4'd4, 4'd5, 4'd0};
	localparam logic [3:0] MAT_PB [N_MAT] =
		'{4'd2, 4'd8, 4'd7, 4'd8, 4'd2, 4'd6, 4'd7, 4'd6, 4'd1};
	localparam logic [N_MAT-1:0] MAT_NA   = 9'b100010001;
	localparam logic [N_MAT-1:0] MAT_NB   = 9'b110011101;
	localparam logic [N_MAT-1:0] MAT_UNIT = 9'b100010001;

	// Stage 1: operand selection and the element-wise operations.
	logic signed [31:0] av [4];
	logic signed [31:0] bv [4];
	logic signed [31:0] opd [8];
	logic signed [31:0] mx [N_MUL];
	logic signed [31:0] my [N_MUL];
	qalu_side_t         side_d;

	logic               v_s1;
	logic signed [31:0] mx_s1 [N_MUL];
	logic signed [31:0] my_s1 [N_MUL];
	qalu_side_t         side_s1;

	always_comb begin
		av[0] = in_data.a_w; av[1] = in_data.a_x; av[2] = in_data.a_y; av[3] = in_data.a_z;
		bv[0] = in_data.b_w; bv[1] = in_data.b_x; bv[2] = in_data.b_y; bv[3] = in_data.b_z;
		for (int i = 0; i < 4; i++) begin
			opd[i]     = av[i];
			opd[i + 4] = bv[i];
		end
	end

	always_comb begin
		logic signed [32:0] sv;
		logic [32:0]        sw;
		side_d         = '0;
		side_d.op      = in_data.opcode;
		side_d.res_sat = 1'b0;
		for (int i = 0; i < 4; i++) begin
			side_d.a[i] = av[i];
			unique case (in_data.opcode)
				OP_ADD:  sv = {av[i][31], av[i]} + {bv[i][31], bv[i]};
				OP_SUB:  sv = {av[i][31], av[i]} - {bv[i][31], bv[i]};
				OP_NEG:  sv = -{av[i][31], av[i]};
				OP_CONJ: sv = (i == 0) ? {av[i][31], av[i]} : -{av[i][31], av[i]};
				default: sv = '0;
			endcase
			sw = sat_word($signed({{35{sv[32]}}, sv}));
			side_d.res[i]  = sw[31:0];
			side_d.res_sat = side_d.res_sat | sw[32];
		end
	end

	always_comb begin
		for (int k = 0; k < N_MUL; k++) begin
			mx[k] = '0;
			my[k] = '0;
		end
		unique case (in_data.opcode)
			OP_MUL: begin
				for (int k = 0; k < N_MUL; k++) begin
					mx[k] = opd[MUL_X_SEL[k]];
					my[k] = opd[MUL_Y_SEL[k]];
				end
			end
			OP_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					mx[4*i] = av[i];
					my[4*i] = bv[0];
				end
			end
			OP_MAG, OP_NORM: begin
				for (int i = 0; i < 4; i++) begin
					mx[i] = av[i];
					my[i] = av[i];
				end
			end
			OP_MAT: begin
				for (int k = 0; k < N_MAT; k++) begin
					mx[k] = av[MAT_X_SEL[k]];
					my[k] = av[MAT_Y_SEL[k]];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && (in_data.opcode <= OP_NORM);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1   <= mx;
			my_s1   <= my;
			side_s1 <= side_d;
		end
	end

	// Stage 2: products.
	logic               v_s2;
	logic signed [63:0] p_s2 [N_MUL];
	qalu_side_t         side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_MUL; k++) begin
				p_s2[k] <= mx_s1[k] * my_s1[k];
			end
			side_s2 <= side_s1;
		end
	end

	// Stage 3: exact sums of the products.
	logic signed [65:0] lane_sum [4];
	logic signed [66:0] mat_sum [N_MAT];

	always_comb begin
		logic signed [65:0] term;
		logic signed [65:0] ta;
		logic signed [65:0] tb;
		logic signed [65:0] pair;
		for (int l = 0; l < 4; l++) begin
			lane_sum[l] = '0;
			for (int t = 0; t < 4; t++) begin
				term = {{2{p_s2[4*l+t][63]}}, p_s2[4*l+t]};
				if ((side_s2.op == OP_MUL) && MUL_NEG[4*l+t]) begin
					lane_sum[l] = lane_sum[l] - term;
				end else begin
					lane_sum[l] = lane_sum[l] + term;
				end
			end
		end
		for (int j = 0; j < N_MAT; j++) begin
			ta = {{2{p_s2[MAT_PA[j]][63]}}, p_s2[MAT_PA[j]]};
			tb = {{2{p_s2[MAT_PB[j]][63]}}, p_s2[MAT_PB[j]]};
			pair = (MAT_NA[j] ? -ta : ta) + (MAT_NB[j] ? -tb : tb);
			mat_sum[j] = {pair, 1'b0};
		end
	end

	logic               v_s3;
	logic signed [65:0] lane_s3 [4];
	logic signed [66:0] mat_s3 [N_MAT];
	qalu_side_t         side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s3 <= lane_sum;
			mat_s3  <= mat_sum;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: one rounding, half toward plus infinity, then saturation.
	qalu_side_t side_r;

	always_comb begin
		logic signed [67:0] t;
		logic [32:0]        sw;
		logic [3:0]         lsat;
		logic [N_MAT-1:0]   msat;
		word_t [3:0]        lres;
		word_t [N_MAT-1:0]  mres;
		for (int l = 0; l < 4; l++) begin
			t = ($signed({{2{lane_s3[l][65]}}, lane_s3[l]}) + HALF) >>> FRAC_BITS;
			sw = sat_word(t);
			lres[l] = sw[31:0];
			lsat[l] = sw[32];
		end
		for (int j = 0; j < N_MAT; j++) begin
			t = ($signed({mat_s3[j][66], mat_s3[j]}) + HALF) >>> FRAC_BITS;
			if (MAT_UNIT[j]) begin
				t = t + ONE;
			end
			sw = sat_word(t);
			mres[j] = sw[31:0];
			msat[j] = sw[32];
		end
		side_r = side_s3;
		unique case (side_s3.op)
			OP_SCALE, OP_MUL: begin
				side_r.res     = lres;
				side_r.res_sat = |lsat;
			end
			OP_MAT: begin
				side_r.mat     = mres;
				side_r.row_sat = {|msat[8:6], |msat[5:3], |msat[2:0]};
			end
			default: ;
		endcase
	end

	logic        v_s4;
	logic [64:0] sq_s4;
	qalu_side_t  side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	// For magnitude the first lane holds the non-negative sum of squares.
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4   <= lane_s3[0][64:0];
			side_s4 <= side_r;
		end
	end

	assign out_valid = v_s4;
	assign sq_sum    = sq_s4;
	assign out_side  = side_s4;

endmodule

/* rtl/core/qalu_sqrt.sv */
// Integer square root pipeline: one root bit per stage over a 64-bit sum of squares.
module qalu_sqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [64:0]           in_sum,
	input  qalu_pkg::qalu_side_t  in_side,
	output logic                  out_valid,
	output logic [31:0]           root,
	output logic [34:0]           rem,
	output logic                  ovf,
	output qalu_pkg::qalu_side_t  out_side
);
	import qalu_pkg::*;

	localparam int STEPS = 32;

	logic        v_s    [STEPS];
	logic [31:0] root_s [STEPS];
	logic [34:0] rem_s  [STEPS];
	logic [63:0] sum_s  [STEPS];
	logic        ovf_s  [STEPS];
	qalu_side_t  side_s [STEPS];

	logic        v_d    [STEPS];
	logic [31:0] root_d [STEPS];
	logic [34:0] rem_d  [STEPS];
	logic [63:0] sum_d  [STEPS];
	logic        ovf_d  [STEPS];
	qalu_side_t  side_d [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [34:0] sh;
		logic [34:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign v_d[k]    = in_valid;
			assign root_d[k] = '0;
			assign rem_d[k]  = '0;
			assign sum_d[k]  = in_sum[63:0];
			assign ovf_d[k]  = in_sum[64];
			assign side_d[k] = in_side;
		end else begin : g_next
			assign v_d[k]    = v_s[k-1];
			assign root_d[k] = root_s[k-1];
			assign rem_d[k]  = rem_s[k-1];
			assign sum_d[k]  = sum_s[k-1];
			assign ovf_d[k]  = ovf_s[k-1];
			assign side_d[k] = side_s[k-1];
		end

		// The remainder never exceeds twice the root, so its top bits are free.
		assign sh    = {rem_d[k][32:0], sum_d[k][63-2*k -: 2]};
		assign trial = {1'b0, root_d[k], 2'b01};
		assign ge    = (sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= {root_d[k][30:0], ge};
				rem_s[k]  <= ge ? (sh - trial) : sh;
				sum_s[k]  <= sum_d[k];
				ovf_s[k]  <= ovf_d[k];
				side_s[k] <= side_d[k];
			end
		end
	end

	assign out_valid = v_s[STEPS-1];
	assign root      = root_s[STEPS-1];
	assign rem       = rem_s[STEPS-1];
	assign ovf       = ovf_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

/* rtl/core/qalu_div.sv */
// Magnitude rounding and a four-lane restoring divider for normalisation.
module qalu_div #(
	parameter int FRAC_BITS = qalu_pkg::QALU_FRAC_BITS,
	parameter int NUM_W     = 32 + FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [31:0]           root,
	input  logic [34:0]           rem,
	input  logic                  ovf,
	input  qalu_pkg::qalu_side_t  in_side,
	output logic                  out_valid,
	output logic [32:0]           mag,
	output logic [NUM_W-1:0]      quot [4],
	output qalu_pkg::qalu_side_t  out_side
);
	import qalu_pkg::*;

	// Stage 1: round the root to nearest; a sum of 2^64 gives 2^32.
	logic        v_s1;
	logic [32:0] m_s1;
	qalu_side_t  side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf) begin
				m_s1 <= {1'b1, 32'h0};
			end else begin
				m_s1 <= {1'b0, root} + {32'h0, (rem > {3'b000, root})};
			end
			side_s1 <= in_side;
		end
	end

	// Stage 2: dividends |a| * 2^FRAC_BITS + m / 2.
	logic             v_s2;
	logic [32:0]      m_s2;
	logic [NUM_W-1:0] num_s2 [4];
	qalu_side_t       side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] mag_a;
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mag_a = side_s1.a[i][31] ? (32'h0 - side_s1.a[i]) : side_s1.a[i];
				num_s2[i] <= (NUM_W'(mag_a) << FRAC_BITS) + NUM_W'(m_s1[32:1]);
			end
			m_s2    <= m_s1;
			side_s2 <= side_s1;
		end
	end

	// Restoring division, one quotient bit per stage, four lanes side by side.
	logic             v_s    [NUM_W];
	logic [32:0]      m_s    [NUM_W];
	logic [NUM_W-1:0] num_s  [NUM_W][4];
	logic [31:0]      rem_s  [NUM_W][4];
	logic [NUM_W-1:0] q_s    [NUM_W][4];
	qalu_side_t       side_s [NUM_W];

	logic             v_d    [NUM_W];
	logic [32:0]      m_d    [NUM_W];
	logic [NUM_W-1:0] num_d  [NUM_W][4];
	logic [31:0]      rem_d  [NUM_W][4];
	logic [NUM_W-1:0] q_d    [NUM_W][4];
	qalu_side_t       side_d [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic [32:0] sh   [4];
		logic [32:0] diff [4];
		logic        ge   [4];

		if (k == 0) begin : g_first
			assign v_d[k]    = v_s2;
			assign m_d[k]    = m_s2;
			assign side_d[k] = side_s2;
			for (genvar i = 0; i < 4; i++) begin : g_lane
				assign num_d[k][i] = num_s2[i];
				assign rem_d[k][i] = '0;
				assign q_d[k][i]   = '0;
			end
		end else begin : g_next
			assign v_d[k]    = v_s[k-1];
			assign m_d[k]    = m_s[k-1];
			assign side_d[k] = side_s[k-1];
			for (genvar i = 0; i < 4; i++) begin : g_lane
				assign num_d[k][i] = num_s[k-1][i];
				assign rem_d[k][i] = rem_s[k-1][i];
				assign q_d[k][i]   = q_s[k-1][i];
			end
		end

		for (genvar i = 0; i < 4; i++) begin : g_cmp
			assign sh[i]   = {rem_d[k][i], num_d[k][i][NUM_W-1-k]};
			assign diff[i] = sh[i] - m_d[k];
			assign ge[i]   = (sh[i] >= m_d[k]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_d[k];
			end
		end

		// The remainder stays below the divisor, so 32 bits hold it.
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 4; i++) begin
					rem_s[k][i] <= ge[i] ? diff[i][31:0] : sh[i][31:0];
					q_s[k][i]   <= {q_d[k][i][NUM_W-2:0], ge[i]};
					num_s[k][i] <= num_d[k][i];
				end
				m_s[k]    <= m_d[k];
				side_s[k] <= side_d[k];
			end
		end
	end

	assign out_valid = v_s[NUM_W-1];
	assign mag       = m_s[NUM_W-1];
	assign quot      = q_s[NUM_W-1];
	assign out_side  = side_s[NUM_W-1];

endmodule

/* rtl/core/quaternion_alu_core.sv */
// Quaternion arithmetic unit in signed fixed point: top level with output sequencer.
//
// Takes one item per clock while the pipeline does not wait. Every item goes
// through 4 front stages, 32 square-root stages, 2 rounding stages,
// 32 + FRAC_BITS divider stages and the output register, the same path
// for every opcode so that results leave in order. Every operation gives one
// result, except the rotation matrix, which holds the output register for
// four transfers, one row each, so the pipeline may wait while a matrix item
// is sent. Unused opcodes are taken and give no result. While the last
// pipeline stage holds an item that the output register cannot take, the
// whole pipeline waits.
module quaternion_alu_core #(
	parameter int FRAC_BITS = qalu_pkg::QALU_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	qalu_stream_if.sink   item,
	qalu_stream_if.source result
);
	import qalu_pkg::*;

	localparam int NUM_W = 32 + FRAC_BITS;
	localparam logic [31:0] ONE_W = 32'd1 << FRAC_BITS;

	logic en;

	logic        fr_valid;
	logic [64:0] fr_sum;
	qalu_side_t  fr_side;

	logic        sq_valid;
	logic [31:0] sq_root;
	logic [34:0] sq_rem;
	logic        sq_ovf;
	qalu_side_t  sq_side;

	logic             dv_valid;
	logic [32:0]      dv_mag;
	logic [NUM_W-1:0] dv_quot [4];
	qalu_side_t       dv_side;

	qalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (item.valid),
		.in_data  (item.data),
		.out_valid(fr_valid),
		.sq_sum   (fr_sum),
		.out_side (fr_side)
	);

	qalu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.in_sum   (fr_sum),
		.in_side  (fr_side),
		.out_valid(sq_valid),
		.root     (sq_root),
		.rem      (sq_rem),
		.ovf      (sq_ovf),
		.out_side (sq_side)
	);

	qalu_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.root     (sq_root),
		.rem      (sq_rem),
		.ovf      (sq_ovf),
		.in_side  (sq_side),
		.out_valid(dv_valid),
		.mag      (dv_mag),
		.quot     (dv_quot),
		.out_side (dv_side)
	);

	// Final selection for magnitude and normalise.
	word_t [3:0] fin_res;
	logic        fin_sat;

	always_comb begin
		logic signed [67:0] qv;
		logic [32:0]        sw;
		fin_res = dv_side.res;
		fin_sat = dv_side.res_sat;
		unique case (dv_side.op)
			OP_MAG: begin
				fin_res = '0;
				if (dv_mag > 33'd2147483647) begin
					fin_res[0] = 32'h7FFF_FFFF;
					fin_sat    = 1'b1;
				end else begin
					fin_res[0] = dv_mag[31:0];
					fin_sat    = 1'b0;
				end
			end
			OP_NORM: begin
				fin_res = '0;
				if (dv_mag == '0) begin
					fin_sat = 1'b1;
				end else begin
					fin_sat = 1'b0;
					for (int i = 0; i < 4; i++) begin
						qv = $signed({{(68-NUM_W){1'b0}}, dv_quot[i]});
						if (dv_side.a[i][31]) begin
							qv = -qv;
						end
						sw = sat_word(qv);
						fin_res[i] = sw[31:0];
						fin_sat    = fin_sat | sw[32];
					end
				end
			end
			default: ;
		endcase
	end

	// Output register with the row sequencer for matrix items.
	logic              out_v_q;
	logic              out_mat_q;
	logic [1:0]        row_q;
	word_t [3:0]       out_res_q;
	logic              out_sat_q;
	word_t [N_MAT-1:0] out_matw_q;
	logic [2:0]        out_rsat_q;
	logic              out_final;
	logic              out_load;

	assign out_final = !out_mat_q || (row_q == 2'd3);
	assign out_load  = !out_v_q || (result.ready && out_final);
	assign en        = !dv_valid || out_load;
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			row_q   <= '0;
		end else if (out_load) begin
			out_v_q <= dv_valid;
			row_q   <= '0;
		end else if (result.ready) begin
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && dv_valid) begin
			out_mat_q  <= (dv_side.op == OP_MAT);
			out_res_q  <= fin_res;
			out_sat_q  <= fin_sat;
			out_matw_q <= dv_side.mat;
			out_rsat_q <= dv_side.row_sat;
		end
	end

	always_comb begin
		result.valid = out_v_q;
		if (out_mat_q) begin
			result.data.row  = row_q;
			result.data.last = (row_q == 2'd3);
			unique case (row_q)
				2'd0: begin
					result.data.c0        = out_matw_q[0];
					result.data.c1        = out_matw_q[1];
					result.data.c2        = out_matw_q[2];
					result.data.c3        = '0;
					result.data.saturated = out_rsat_q[0];
				end
				2'd1: begin
					result.data.c0        = out_matw_q[3];
					result.data.c1        = out_matw_q[4];
					result.data.c2        = out_matw_q[5];
					result.data.c3        = '0;
					result.data.saturated = out_rsat_q[1];
				end
				2'd2: begin
					result.data.c0        = out_matw_q[6];
					result.data.c1        = out_matw_q[7];
					result.data.c2        = out_matw_q[8];
					result.data.c3        = '0;
					result.data.saturated = out_rsat_q[2];
				end
				2'd3: begin
					result.data.c0        = '0;
					result.data.c1        = '0;
					result.data.c2        = '0;
					result.data.c3        = ONE_W;
					result.data.saturated = 1'b0;
				end
			endcase
		end else begin
			result.data.c0        = out_res_q[0];
			result.data.c1        = out_res_q[1];
			result.data.c2        = out_res_q[2];
			result.data.c3        = out_res_q[3];
			result.data.row       = '0;
			result.data.last      = 1'b1;
			result.data.saturated = out_sat_q;
		end
	end

	// Rows beyond the first only occur while a matrix item is being sent.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (row_q != 2'd0)) |-> out_mat_q)
		else $error("row counter advanced on a single-result item");

	// After the final transfer of an item the row count starts again.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && result.data.last) |=> (row_q == 2'd0))
		else $error("row counter not cleared after final transfer");

	// The pipeline only stalls while its last stage holds an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> (dv_valid && out_v_q))
		else $error("pipeline stalled without a waiting item");

endmodule

/* tb/quaternion_alu_core_tb.sv */
// Self-checking testbench for the quaternion arithmetic unit: directed table, then random items.
`timescale 1ns / 100ps

module quaternion_alu_core_tb;
	import qalu_pkg::*;

	localparam int FB = QALU_FRAC_BITS;
	localparam int LATENCY = FB + 71;
	localparam int N_DIRECTED = 22;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qalu_stream_if #(.data_t(qalu_in_t))  item_ch();
	qalu_stream_if #(.data_t(qalu_out_t)) result_ch();

	quaternion_alu_core #(.FRAC_BITS(FB)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

	typedef struct {
		qalu_in_t  stim;
		bit        has_lit;
		qalu_out_t lit;
	} table_row_t;

	qalu_out_t expected_q[$];
	int        mismatch_cnt = 0;
	int        result_cnt = 0;
	int        item_cnt = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	table_row_t stim_table[N_DIRECTED];

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v, ref bit f);
		if (v > 128'sd2147483647) begin
			f = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -128'sd2147483648) begin
			f = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Exact sum, then one rounding half toward plus infinity.
	function automatic logic signed [127:0] round_frac(input logic signed [127:0] s);
		return (s + (128'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	function automatic logic [63:0] rounded_mag(input logic signed [31:0] q[4]);
		logic [127:0] s;
		logic [127:0] r;
		logic [127:0] b;
		s = 0;
		for (int i = 0; i < 4; i++) s += 128'(($signed(128'(q[i]))) * $signed(128'(q[i])));
		r = 0;
		// The root of a sum below 2^65 fits in 33 bits.
		for (int k = 33; k >= 0; k--) begin
			b = r | (128'd1 << k);
			if (b * b <= s) r = b;
		end
		if (s - r * r > r) r++;
		return r[63:0];
	endfunction

	function automatic logic signed [127:0] mat_elem(input logic signed [127:0] p1,
			input logic signed [127:0] p2, input bit unit);
		logic signed [127:0] s;
		s = 2 * p1 + 2 * p2;
		if (unit) s += 128'sd1 <<< (2 * FB);
		return round_frac(s);
	endfunction

	task automatic predict_quat(input qalu_in_t it);
		logic signed [31:0] a[4];
		logic signed [31:0] b[4];
		logic signed [127:0] v[4];
		logic signed [127:0] m[9];
		logic signed [127:0] w, x, y, z;
		logic [63:0] mag;
		logic [127:0] n;
		logic [127:0] qv;
		qalu_out_t r;
		bit f;
		a = '{it.a_w, it.a_x, it.a_y, it.a_z};
		b = '{it.b_w, it.b_x, it.b_y, it.b_z};
		f = 1'b0;
		r = '0;
		r.last = 1'b1;
		for (int i = 0; i < 4; i++) v[i] = 0;
		case (it.opcode)
			OP_ADD: for (int i = 0; i < 4; i++) v[i] = 128'(a[i]) + 128'(b[i]);
			OP_SUB: for (int i = 0; i < 4; i++) v[i] = 128'(a[i]) - 128'(b[i]);
			OP_NEG: for (int i = 0; i < 4; i++) v[i] = -128'(a[i]);
			OP_CONJ: for (int i = 0; i < 4; i++) v[i] = (i == 0) ? 128'(a[i]) : -128'(a[i]);
			OP_SCALE: for (int i = 0; i < 4; i++) v[i] = round_frac(128'(a[i]) * 128'(b[0]));
			OP_MUL: begin
				v[0] = round_frac(128'(a[0]) * b[0] - 128'(a[1]) * b[1]
					- 128'(a[2]) * b[2] - 128'(a[3]) * b[3]);
				v[1] = round_frac(128'(a[2]) * b[3] - 128'(a[3]) * b[2]
					+ 128'(a[0]) * b[1] + 128'(b[0]) * a[1]);
				v[2] = round_frac(128'(a[3]) * b[1] - 128'(a[1]) * b[3]
					+ 128'(a[0]) * b[2] + 128'(b[0]) * a[2]);
				v[3] = round_frac(128'(a[1]) * b[2] - 128'(a[2]) * b[1]
					+ 128'(a[0]) * b[3] + 128'(b[0]) * a[3]);
			end
			OP_MAT: begin
				w = a[0]; x = a[1]; y = a[2]; z = a[3];
				m[0] = mat_elem(-y * y, -z * z, 1);
				m[1] = mat_elem(x * y, w * z, 0);
				m[2] = mat_elem(x * z, -w * y, 0);
				m[3] = mat_elem(x * y, -w * z, 0);
				m[4] = mat_elem(-x * x, -z * z, 1);
				m[5] = mat_elem(y * z, w * x, 0);
				m[6] = mat_elem(x * z, w * y, 0);
				m[7] = mat_elem(y * z, -w * x, 0);
				m[8] = mat_elem(-x * x, -y * y, 1);
				for (int rw = 0; rw < 3; rw++) begin
					f = 1'b0;
					r = '0;
					r.c0 = clamp32(m[rw * 3], f);
					r.c1 = clamp32(m[rw * 3 + 1], f);
					r.c2 = clamp32(m[rw * 3 + 2], f);
					r.row = rw[1:0];
					r.saturated = f;
					expected_q.push_back(r);
				end
				r = '0;
				r.c3 = 32'sd1 <<< FB;
				r.row = 2'd3;
				r.last = 1'b1;
				expected_q.push_back(r);
				return;
			end
			OP_MAG: begin
				mag = rounded_mag(a);
				v[0] = 128'(mag);
			end
			OP_NORM: begin
				mag = rounded_mag(a);
				if (mag == 0) begin
					f = 1'b1;
				end else begin
					for (int i = 0; i < 4; i++) begin
						n = (a[i] < 0 ? 128'(-128'(a[i])) : 128'(a[i])) << FB;
						qv = (n + mag / 2) / mag;
						v[i] = a[i] < 0 ? -$signed(qv) : $signed(qv);
					end
				end
			end
			default: return;
		endcase
		r.c0 = clamp32(v[0], f);
		r.c1 = clamp32(v[1], f);
		r.c2 = clamp32(v[2], f);
		r.c3 = clamp32(v[3], f);
		r.saturated = f;
		expected_q.push_back(r);
	endtask

	function automatic qalu_in_t mk(input logic [3:0] op, input int aw, ax, ay, az,
			input int bw, bx, by, bz);
		return '{op, aw, ax, ay, az, bw, bx, by, bz};
	endfunction

	function automatic qalu_out_t mkr(input int c0, c1, c2, c3, input bit sat);
		return '{c0, c1, c2, c3, 2'd0, 1'b1, sat};
	endfunction

	localparam int ONE = 1 << FB;
	localparam int MAXV = 32'h7FFF_FFFF;
	localparam int MINV = 32'h8000_0000;

	initial begin
		stim_table = '{
			'{mk(OP_ADD, 1, 2, 3, 4, 5, 6, 7, 8), 1, mkr(6, 8, 10, 12, 0)},
			'{mk(OP_ADD, MAXV, MINV, 0, -1, 1, -1, 0, 1), 1, mkr(MAXV, MINV, 0, 0, 1)},
			'{mk(OP_SUB, MINV, MAXV, 5, 0, 1, -1, 5, 0), 1, mkr(MINV, MAXV, 0, 0, 1)},
			'{mk(OP_NEG, MINV, MAXV, -1, 0, 0, 0, 0, 0), 1, mkr(MAXV, MINV + 1, 1, 0, 1)},
			'{mk(OP_CONJ, MINV, MINV, 7, -7, 0, 0, 0, 0), 1, mkr(MINV, MAXV, -7, 7, 1)},
			'{mk(OP_SCALE, ONE, -ONE, 3, MAXV, ONE, 0, 0, 0), 1, mkr(ONE, -ONE, 3, MAXV, 0)},
			'{mk(OP_SCALE, MAXV, MINV, 1, -1, MAXV, 0, 0, 0), 0, '0},
			'{mk(OP_SCALE, 1, -1, 3, -3, 32'h8000, 0, 0, 0), 0, '0},
			'{mk(OP_MUL, ONE, 0, 0, 0, ONE, 2, 3, 4), 1, mkr(ONE, 2, 3, 4, 0)},
			'{mk(OP_MUL, 0, ONE, 0, 0, 0, ONE, 0, 0), 1, mkr(-ONE, 0, 0, 0, 0)},
			'{mk(OP_MUL, MINV, MINV, MINV, MINV, MINV, MAXV, MINV, MAXV), 0, '0},
			'{mk(OP_MUL, 12345, -999, 77777, -4, 31, 65535, -65536, 9), 0, '0},
			'{mk(OP_MAT, ONE, 0, 0, 0, 0, 0, 0, 0), 0, '0},
			'{mk(OP_MAT, MINV, MAXV, MINV, MAXV, 0, 0, 0, 0), 0, '0},
			'{mk(OP_MAT, 46341, 0, 46341, 0, 0, 0, 0, 0), 0, '0},
			'{mk(OP_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0), 1, mkr(5 * ONE, 0, 0, 0, 0)},
			'{mk(OP_MAG, MINV, MINV, MINV, MINV, 0, 0, 0, 0), 1, mkr(MAXV, 0, 0, 0, 1)},
			'{mk(OP_MAG, 0, 0, 0, 0, 0, 0, 0, 0), 1, mkr(0, 0, 0, 0, 0)},
			'{mk(OP_NORM, 0, 0, 0, 0, 1, 2, 3, 4), 1, mkr(0, 0, 0, 0, 1)},
			'{mk(OP_NORM, 0, 0, 0, 1, 0, 0, 0, 0), 1, mkr(0, 0, 0, ONE, 0)},
			'{mk(OP_NORM, MINV, MAXV, 3, -3, 0, 0, 0, 0), 0, '0},
			'{mk(4'd12, 1, 2, 3, 4, 5, 6, 7, 8), 0, '0}
		};
	end

	function automatic int rand_word();
		case ($urandom_range(0, 5))
			0: return MAXV;
			1: return MINV;
			2: return $urandom_range(0, 2 * ONE) - ONE;
			3: return $urandom_range(0, 8 * ONE) - 4 * ONE;
			default: return $urandom;
		endcase
	endfunction

	// Valid drops only while the sender idles, so it is written once per clock at most.
	task automatic send_item(input qalu_in_t it);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do @(posedge clk); while (!item_ch.ready);
		predict_quat(it);
		item_cnt++;
	endtask

	// Receiver side: ready toggles at random, each transfer checked against the queue.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				result_cnt++;
				if (expected_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result %p", result_ch.data);
				end else if (result_ch.data !== expected_q[0]) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: expected %p, got %p", expected_q[0],
							result_ch.data);
					void'(expected_q.pop_front());
				end else begin
					void'(expected_q.pop_front());
				end
			end
			result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		qalu_in_t it;
		int wait_cnt;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 33;
		recv_idle_pct = 71;
		foreach (stim_table[i]) begin
			send_item(stim_table[i].stim);
			if (stim_table[i].has_lit) expected_q[$] = stim_table[i].lit;
		end
		for (int k = 0; k < 138; k++) begin
			if (k == 46) begin
				send_idle_pct = 71;
				recv_idle_pct = 33;
			end else if (k == 92) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			it = mk(4'($urandom_range(0, 8)), rand_word(), rand_word(), rand_word(),
				rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
			if ($urandom_range(0, 19) == 0) it.opcode = 4'($urandom_range(9, 15));
			send_item(it);
		end
		item_ch.valid <= 1'b0;
		wait_cnt = 0;
		while (expected_q.size() != 0 && wait_cnt < 200000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (LATENCY + 20) @(posedge clk);
		$display("%0d items sent over three idling patterns, %0d results checked.",
			item_cnt, result_cnt);
		if (mismatch_cnt == 0 && expected_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/qalu_pkg.sv
rtl/core/qalu_stream_if.sv
rtl/core/qalu_front.sv
rtl/core/qalu_sqrt.sv
rtl/core/qalu_div.sv
rtl/core/quaternion_alu_core.sv
tb/quaternion_alu_core_tb.sv
